FILE: hw/rtl/brf_pkg.sv
package brf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 4;
  localparam int unsigned ModeW = 3;

  // Physical store: shared r0-r15, fast-interrupt r8-r14, stack/link pairs
  // for svc, abort, irq and undefined, then one saved status word per
  // exception mode.
  localparam int unsigned SharedBase = 0;
  localparam int unsigned FiqBase    = 16;
  localparam int unsigned SlBase     = 23;
  localparam int unsigned SpsrBase   = 31;
  localparam int unsigned MemDepth   = 36;
  localparam int unsigned AddrW      = $clog2(MemDepth);

  localparam logic [DataW-1:0] StackReset = 32'h0300_7F00;
  localparam logic [DataW-1:0] PcReset    = 32'h0800_0000;

  localparam logic [RegW-1:0] RegStack = 4'd13;
  localparam logic [RegW-1:0] RegLink  = 4'd14;
  localparam logic [RegW-1:0] RegPc    = 4'd15;

  typedef enum logic [1:0] {
    OP_READ_REG    = 2'd0,
    OP_WRITE_REG   = 2'd1,
    OP_READ_SPSR   = 2'd2,
    OP_WRITE_SPSR  = 2'd3
  } brf_op_t;

  typedef enum logic [ModeW-1:0] {
    MODE_SYS = 3'd0,
    MODE_FIQ = 3'd1,
    MODE_SVC = 3'd2,
    MODE_ABT = 3'd3,
    MODE_IRQ = 3'd4,
    MODE_UND = 3'd5
  } brf_mode_t;

  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_MEM    = 2'd1,
    KIND_STATUS = 2'd2
  } brf_kind_t;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [AddrW-1:0] addr;
    logic             sys_status;
    brf_kind_t        kind;
  } brf_req_t;

  function automatic logic [DataW-1:0] reset_value(input logic [AddrW-1:0] addr);
    logic [DataW-1:0] v;
    v = '0;
    if (addr == AddrW'(SharedBase + 13) || addr == AddrW'(FiqBase + 5) ||
        addr == AddrW'(SlBase) || addr == AddrW'(SlBase + 2) ||
        addr == AddrW'(SlBase + 4) || addr == AddrW'(SlBase + 6)) begin
      v = StackReset;
    end else if (addr == AddrW'(SharedBase + 15)) begin
      v = PcReset;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/brf_decode.sv
module brf_decode (
  input  logic [1:0]                 opcode,
  input  logic [brf_pkg::RegW-1:0]   reg_index,
  input  logic [brf_pkg::ModeW-1:0]  mode_code,
  output brf_pkg::brf_req_t          req
);

  logic [brf_pkg::ModeW-1:0] mode;
  logic [brf_pkg::ModeW-1:0] mode_less1;
  logic [brf_pkg::ModeW-1:0] mode_less2;
  logic                      is_sys;
  logic                      banked_fiq;
  logic                      banked_sl;
  logic [brf_pkg::AddrW-1:0] reg_addr;

  always_comb begin
    // Unused mode codes behave as system mode.
    mode = (mode_code > brf_pkg::MODE_UND) ? brf_pkg::MODE_SYS : mode_code;
    is_sys = (mode == brf_pkg::MODE_SYS);
    mode_less1 = mode - 3'd1;
    mode_less2 = mode - 3'd2;
    banked_fiq = (reg_index >= 4'd8) && (reg_index <= brf_pkg::RegLink) &&
                 (mode == brf_pkg::MODE_FIQ);
    banked_sl  = ((reg_index == brf_pkg::RegStack) || (reg_index == brf_pkg::RegLink)) &&
                 (mode >= brf_pkg::MODE_SVC);

    if (banked_fiq) begin
      reg_addr = brf_pkg::AddrW'(brf_pkg::FiqBase) +
                 brf_pkg::AddrW'(reg_index[2:0]);
    end else if (banked_sl) begin
      // Stack (r13, odd) lands on the even slot of each pair.
      reg_addr = brf_pkg::AddrW'(brf_pkg::SlBase) +
                 brf_pkg::AddrW'({mode_less2[1:0], ~reg_index[0]});
    end else begin
      reg_addr = brf_pkg::AddrW'(reg_index);
    end

    req = '0;
    case (opcode)
      brf_pkg::OP_READ_REG: begin
        req.rd   = 1'b1;
        req.addr = reg_addr;
        req.kind = brf_pkg::KIND_MEM;
      end
      brf_pkg::OP_WRITE_REG: begin
        req.wr   = 1'b1;
        req.addr = reg_addr;
        req.kind = brf_pkg::KIND_ZERO;
      end
      brf_pkg::OP_READ_SPSR: begin
        req.rd         = !is_sys;
        req.addr       = brf_pkg::AddrW'(brf_pkg::SpsrBase) + brf_pkg::AddrW'(mode_less1);
        req.sys_status = is_sys;
        req.kind       = is_sys ? brf_pkg::KIND_STATUS : brf_pkg::KIND_MEM;
      end
      default: begin
        req.wr         = !is_sys;
        req.addr       = brf_pkg::AddrW'(brf_pkg::SpsrBase) + brf_pkg::AddrW'(mode_less1);
        req.sys_status = is_sys;
        req.kind       = brf_pkg::KIND_ZERO;
      end
    endcase
  end

endmodule

FILE: hw/rtl/brf_store.sv
module brf_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  logic                       rd,
  input  logic [brf_pkg::AddrW-1:0]  addr,
  input  logic [brf_pkg::DataW-1:0]  wdata,
  output logic [brf_pkg::DataW-1:0]  rdata
);

  logic [brf_pkg::DataW-1:0]    mem [brf_pkg::MemDepth];
  logic [brf_pkg::MemDepth-1:0] written;
  logic [brf_pkg::DataW-1:0]    rd_word;
  logic                         rd_written;
  logic [brf_pkg::AddrW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rd_word    <= mem[addr];
      rd_written <= written[addr];
      rd_addr    <= addr;
    end
  end

  // An entry that was never written since reset reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr) begin
      written[addr] <= 1'b1;
    end
  end

  assign rdata = rd_written ? rd_word : brf_pkg::reset_value(rd_addr);

endmodule

FILE: hw/rtl/banked_register_file_unit.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   opcode, reg_index, mode_code, write_value, status_word
// out      out_valid / out_ready read_data, system_mode_status_access
//
// An item is decoded and its memory access issued in the cycle it transfers;
// the result is held in the pending stage until the output register is free,
// so one item can transfer per cycle while the output is not stalled.
// Writes land at the transfer edge, so a following read always sees them.
// Reset is synchronous; every entry reads as its reset value until written.
// A stalled output holds one pending item, after which in_ready drops.
module banked_register_file_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 opcode,
  input  logic [brf_pkg::RegW-1:0]   reg_index,
  input  logic [brf_pkg::ModeW-1:0]  mode_code,
  input  logic [brf_pkg::DataW-1:0]  write_value,
  input  logic [brf_pkg::DataW-1:0]  status_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brf_pkg::DataW-1:0]  read_data,
  output logic                       system_mode_status_access
);

  brf_pkg::brf_req_t         req;
  logic                      accept;
  logic                      pend_valid;
  logic                      pend_move;
  brf_pkg::brf_kind_t        pend_kind;
  logic                      pend_flag;
  logic [brf_pkg::DataW-1:0] pend_status;
  logic [brf_pkg::DataW-1:0] mem_rdata;
  logic [brf_pkg::DataW-1:0] result;

  brf_decode u_decode (
    .opcode    (opcode),
    .reg_index (reg_index),
    .mode_code (mode_code),
    .req       (req)
  );

  brf_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept && req.wr),
    .rd    (accept && req.rd),
    .addr  (req.addr),
    .wdata (write_value),
    .rdata (mem_rdata)
  );

  assign pend_move = pend_valid && (!out_valid || out_ready);
  // No transfer is taken while reset is held.
  assign in_ready  = !rst && (!pend_valid || pend_move);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_kind   <= req.kind;
      pend_flag   <= req.sys_status;
      pend_status <= status_word;
    end
    if (pend_move) begin
      read_data                 <= result;
      system_mode_status_access <= pend_flag;
    end
  end

  always_comb begin
    case (pend_kind)
      brf_pkg::KIND_MEM:    result = mem_rdata;
      brf_pkg::KIND_STATUS: result = pend_status;
      default:              result = '0;
    endcase
  end

endmodule

FILE: dv/tb_banked_register_file_unit.sv
`timescale 1ns / 100ps

module tb_banked_register_file_unit;
  import brf_pkg::*;

  localparam int unsigned RandomItems = 1127;
  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned DrainLimit  = 500;

  // Mode codes 6 and 7 have no name in the package; they behave as system mode.
  localparam logic [ModeW-1:0] ModeSpareLo = 3'd6;
  localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;

  // Layout of the predictor's own register store.
  localparam int unsigned FiqCell    = 16;
  localparam int unsigned PairCell   = 23;
  localparam int unsigned StoreDepth = 31;

  typedef struct {
    logic [DataW-1:0] data;
    logic             flag;
  } access_result_t;

  typedef struct {
    brf_op_t          op;
    logic [RegW-1:0]  idx;
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] wv;
    logic [DataW-1:0] sw;
    bit               typed;
    logic [DataW-1:0] want_data;
    bit               want_flag;
  } access_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       opcode = OP_READ_REG;
  logic [RegW-1:0]  reg_index = '0;
  logic [ModeW-1:0] mode_code = MODE_SYS;
  logic [DataW-1:0] write_value = '0;
  logic [DataW-1:0] status_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] read_data;
  logic             system_mode_status_access;

  // Hand-typed expectation that travels with the item being offered.
  bit               cur_typed = 1'b0;
  logic [DataW-1:0] cur_want_data = '0;
  bit               cur_want_flag = 1'b0;

  logic [DataW-1:0] reg_store [StoreDepth];
  logic [DataW-1:0] saved_status [5];
  access_result_t   pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      results_seen = 0;
  int unsigned      rx_wait = 0;
  bit               tx_burst = 1'b0;

  banked_register_file_unit u_dut (
    .clk                       (clk),
    .rst                       (rst),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .opcode                    (opcode),
    .reg_index                 (reg_index),
    .mode_code                 (mode_code),
    .write_value               (write_value),
    .status_word               (status_word),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .read_data                 (read_data),
    .system_mode_status_access (system_mode_status_access)
  );

  always #10 clk = ~clk;

  task automatic note_mismatch(input string what, input logic [DataW-1:0] got,
                               input logic [DataW-1:0] want);
    $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned cell_of(input logic [RegW-1:0] idx, input brf_mode_t m);
    if (m == MODE_FIQ && idx >= 4'd8 && idx <= RegLink) begin
      return FiqCell + int'(idx) - 8;
    end
    if ((idx == RegStack || idx == RegLink) && m != MODE_SYS && m != MODE_FIQ) begin
      return PairCell + 2 * (int'(m) - int'(MODE_SVC)) + int'(idx) - int'(RegStack);
    end
    return int'(idx);
  endfunction

  // Applies one access to the predicted register file and returns its result.
  function automatic access_result_t apply_access(input brf_op_t op,
                                                  input logic [RegW-1:0] idx,
                                                  input logic [ModeW-1:0] code,
                                                  input logic [DataW-1:0] wv,
                                                  input logic [DataW-1:0] sw);
    access_result_t res;
    brf_mode_t      m;
    m = (code > MODE_UND) ? MODE_SYS : brf_mode_t'(code);
    res.data = '0;
    res.flag = 1'b0;
    case (op)
      OP_READ_REG: begin
        res.data = reg_store[cell_of(idx, m)];
      end
      OP_WRITE_REG: begin
        reg_store[cell_of(idx, m)] = wv;
      end
      OP_READ_SPSR: begin
        if (m == MODE_SYS) begin
          res.data = sw;
          res.flag = 1'b1;
        end else begin
          res.data = saved_status[int'(m) - 1];
        end
      end
      default: begin
        if (m == MODE_SYS) begin
          res.flag = 1'b1;
        end else begin
          saved_status[int'(m) - 1] = wv;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Monitor: checks results first, so an item accepted at the same edge is
  // never matched against itself.
  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    if (rst) begin
      for (int i = 0; i < StoreDepth; i++) begin
        reg_store[i] = '0;
      end
      for (int i = 0; i < 5; i++) begin
        saved_status[i] = '0;
      end
      reg_store[RegStack] = StackReset;
      reg_store[RegPc] = PcReset;
      reg_store[FiqCell + 5] = StackReset;
      for (int i = 0; i < 4; i++) begin
        reg_store[PairCell + 2 * i] = StackReset;
      end
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing expected", read_data, '0);
        end else begin
          want = pending_results.pop_front();
          if (read_data !== want.data) begin
            note_mismatch("read_data", read_data, want.data);
          end
          if (system_mode_status_access !== want.flag) begin
            note_mismatch("system_mode_status_access", DataW'(system_mode_status_access),
                          DataW'(want.flag));
          end
        end
        rx_wait = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 7);
        if (rx_wait != 0) begin
          out_ready <= 1'b0;
          rx_wait <= rx_wait - 1;
        end
      end else if (!out_ready) begin
        if (rx_wait == 0) begin
          out_ready <= 1'b1;
        end else begin
          rx_wait <= rx_wait - 1;
        end
      end
      if (in_valid && in_ready) begin
        got = apply_access(brf_op_t'(opcode), reg_index, mode_code, write_value, status_word);
        if (cur_typed) begin
          got.data = cur_want_data;
          got.flag = cur_want_flag;
        end
        pending_results.push_back(got);
      end
    end
  end

  task automatic offer_access(input access_row_t row);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= row.op;
    reg_index     <= row.idx;
    mode_code     <= row.mode;
    write_value   <= row.wv;
    status_word   <= row.sw;
    cur_typed     <= row.typed;
    cur_want_data <= row.want_data;
    cur_want_flag <= row.want_flag;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    access_row_t directed_rows [23];
    access_row_t row;
    int unsigned drain;

    directed_rows = '{
      '{OP_READ_REG,   RegStack, MODE_SYS,    '0, '0, 1, StackReset, 0},
      '{OP_READ_REG,   RegPc,    MODE_SYS,    '0, '0, 1, PcReset,    0},
      '{OP_READ_REG,   4'd0,     MODE_SYS,    '1, '1, 1, '0,         0},
      '{OP_READ_REG,   RegStack, MODE_FIQ,    '0, '0, 1, StackReset, 0},
      '{OP_READ_REG,   RegLink,  MODE_SVC,    '0, '0, 1, '0,         0},
      '{OP_READ_REG,   RegStack, MODE_UND,    '0, '0, 1, StackReset, 0},
      '{OP_READ_SPSR,  4'd3,     ModeSpareLo, '0, '1, 1, '1,         1},
      '{OP_WRITE_SPSR, 4'd0,     MODE_SYS,    '1, '0, 1, '0,         1},
      '{OP_READ_SPSR,  4'd0,     MODE_IRQ,    '0, '1, 1, '0,         0},
      '{OP_WRITE_REG,  4'd8,     MODE_FIQ,    '1, '0, 1, '0,         0},
      '{OP_READ_REG,   4'd8,     MODE_SYS,    '0, '0, 1, '0,         0},
      '{OP_READ_REG,   4'd8,     MODE_FIQ,    '0, '0, 0, '0,         0},
      '{OP_WRITE_REG,  RegStack, ModeSpareHi, '0, '0, 0, '0,         0},
      '{OP_READ_REG,   RegStack, MODE_SYS,    '0, '0, 0, '0,         0},
      '{OP_WRITE_REG,  RegLink,  MODE_ABT,    '1, '0, 0, '0,         0},
      '{OP_READ_REG,   RegLink,  MODE_ABT,    '0, '0, 0, '0,         0},
      '{OP_WRITE_SPSR, RegPc,    MODE_UND,    32'hA5A5_A5A5, '0, 0, '0, 0},
      '{OP_READ_SPSR,  4'd0,     MODE_UND,    '0, '0, 0, '0,         0},
      '{OP_READ_SPSR,  4'd0,     ModeSpareHi, '1, '0, 1, '0,         1},
      '{OP_WRITE_REG,  RegPc,    MODE_UND,    32'h1234_5678, '0, 0, '0, 0},
      '{OP_READ_REG,   RegPc,    MODE_FIQ,    '0, '0, 0, '0,         0},
      '{OP_WRITE_SPSR, 4'd9,     MODE_FIQ,    32'h8000_0001, '0, 0, '0, 0},
      '{OP_READ_SPSR,  4'd9,     MODE_FIQ,    '0, '0, 0, '0,         0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_access(directed_rows[i]);
    end

    row.typed = 1'b0;
    row.want_data = '0;
    row.want_flag = 1'b0;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      tx_burst = ((n / 48) % 3 == 1);
      row.op = brf_op_t'($urandom_range(0, 3));
      // Lean on the banked registers, where the mode decides the storage.
      row.idx = ($urandom_range(0, 2) == 0) ? RegW'($urandom_range(8, 15))
                                             : RegW'($urandom_range(0, 15));
      row.mode = ($urandom_range(0, 7) == 0) ? ModeW'($urandom_range(6, 7))
                                             : ModeW'($urandom_range(0, 5));
      row.wv = pick_word();
      row.sw = pick_word();
      offer_access(row);
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch("results never arrived", DataW'(pending_results.size()), '0);
    end

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_decode.sv
hw/rtl/brf_store.sv
hw/rtl/banked_register_file_unit.sv
dv/tb_banked_register_file_unit.sv
